// File: design/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types and constants for the step sequencer voice: action codes,
// register map, step entry layout and the event command word.
// ----------------------------------------------------------------------------
package ssv_pkg;

	localparam int MAX_STEPS     = 64;
	localparam int CHANNEL_COUNT = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam int POS_W  = $clog2(MAX_STEPS);
	localparam int LEN_W  = 7;
	localparam int EFF_W  = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
	localparam int MASK_W = 16;
	localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int QP_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = QP_W + 1;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [MASK_W-1:0] CH_VALID = MASK_W'((64'd1 << CHANNEL_COUNT) - 64'd1);
	localparam logic [6:0]        NOTE_MAX = 7'd127;
	localparam logic [7:0]        NOTE_EMPTY = 8'hFF;
	localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(16);
	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1);

	typedef enum logic [2:0] {
		ACT_WRITE    = 3'd0,
		ACT_ERASE    = 3'd1,
		ACT_SET_POS  = 3'd2,
		ACT_ADVANCE  = 3'd3,
		ACT_NOTE_ON  = 3'd4,
		ACT_NOTE_OFF = 3'd5
	} action_t;

	typedef enum logic {
		EV_NOTE_ON  = 1'b0,
		EV_NOTE_OFF = 1'b1
	} event_kind_t;

	typedef enum logic {
		REG_CHANNEL_MASK = 1'b0,
		REG_SEQ_LENGTH   = 1'b1
	} reg_index_t;

	typedef enum logic {
		FR_IDLE = 1'b0,
		FR_EVAL = 1'b1
	} front_state_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RUN  = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [7:0] note;
		logic [6:0] vel;
		logic [8:0] prob;
	} step_entry_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [15:0] time_stamp;
	} cmd_t;

endpackage

// File: design/ssv_ram.sv
// ----------------------------------------------------------------------------
// ssv_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ssv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ssv_queue.sv
// ----------------------------------------------------------------------------
// ssv_queue
// Short command queue between the classifying front end and the event
// emitter, so each side can stall on its own.
// ----------------------------------------------------------------------------
module ssv_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssv_pkg::cmd_t push_cmd,
	input  logic          pop,
	output ssv_pkg::cmd_t head_cmd,
	output logic          full,
	output logic          empty
);
	import ssv_pkg::*;

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	assign full     = (count_q == QC_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("word pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("word popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QC_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

// File: design/ssv_front.sv
// ----------------------------------------------------------------------------
// ssv_front
// Accepts and classifies input words: keeps the step table, play position
// and sounding note, and turns note-on and note-off actions into commands.
// ----------------------------------------------------------------------------
module ssv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                action,
	input  logic [5:0]                step_index,
	input  logic [7:0]                note_number,
	input  logic [6:0]                note_velocity,
	input  logic [8:0]                note_probability,
	input  logic [7:0]                transposition,
	input  logic [7:0]                random_draw,
	input  logic [15:0]               sample_offset,
	input  logic [ssv_pkg::LEN_W-1:0] seq_length,
	input  logic                      q_full,
	output logic                      push,
	output ssv_pkg::cmd_t             push_cmd
);
	import ssv_pkg::*;

	front_state_t         state_q;
	front_state_t         state_d;
	logic                 eval_en;
	logic                 accept;
	action_t              act;

	logic [POS_W-1:0]     pos_q;
	logic [MAX_STEPS-1:0] step_vld_q;
	logic                 snd_vld_q;
	logic [6:0]           snd_note_q;
	logic [7:0]           trans_q;
	logic [7:0]           draw_q;
	logic [15:0]          time_q;

	logic [EFF_W-1:0]     eff_len;
	logic                 idx_in_len;
	logic [EFF_W-1:0]     pos_inc;
	logic                 ram_we;
	logic                 ram_re;
	step_entry_t          ram_wdata;
	step_entry_t          ram_rdata;
	step_entry_t          cur_step;
	logic                 fire;
	logic signed [8:0]    note_sum;
	logic [6:0]           note_clamped;
	logic                 off_push;

	assign act    = action_t'(action);
	assign accept = start && !busy;

	// zero acts as one, anything above the table acts as the table size
	always_comb begin
		if (seq_length == '0) begin
			eff_len = EFF_W'(1);
		end else if (EFF_W'(seq_length) > EFF_W'(MAX_STEPS)) begin
			eff_len = EFF_W'(MAX_STEPS);
		end else begin
			eff_len = EFF_W'(seq_length);
		end
	end

	assign idx_in_len = (EFF_W'(step_index) < eff_len);
	assign pos_inc    = EFF_W'(pos_q) + EFF_W'(1);

	assign ram_we    = accept && (act == ACT_WRITE) && idx_in_len;
	assign ram_re    = accept && (act == ACT_NOTE_ON);
	assign ram_wdata = '{note: note_number, vel: note_velocity, prob: note_probability};

	ssv_ram #(
		.WIDTH ($bits(step_entry_t)),
		.DEPTH (MAX_STEPS)
	) u_step_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (POS_W'(step_index)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// a step never written or erased reads as empty
	always_comb begin
		cur_step = ram_rdata;
		if (!step_vld_q[pos_q]) begin
			cur_step.note = NOTE_EMPTY;
		end
	end

	assign note_sum = $signed({cur_step.note[7], cur_step.note}) +
		$signed({trans_q[7], trans_q});

	always_comb begin
		if (note_sum < 0) begin
			note_clamped = '0;
		end else if (note_sum > $signed({2'b00, NOTE_MAX})) begin
			note_clamped = NOTE_MAX;
		end else begin
			note_clamped = note_sum[6:0];
		end
	end

	assign fire = eval_en && (EFF_W'(pos_q) < eff_len) &&
		(cur_step.note != NOTE_EMPTY) && ({1'b0, draw_q} <= cur_step.prob);

	assign off_push = accept && (act == ACT_NOTE_OFF) && snd_vld_q;

	always_comb begin
		push = fire || off_push;
		if (fire) begin
			push_cmd = '{kind: EV_NOTE_ON, note: note_clamped, vel: cur_step.vel,
				time_stamp: time_q};
		end else begin
			push_cmd = '{kind: EV_NOTE_OFF, note: snd_note_q, vel: 7'd0,
				time_stamp: sample_offset};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept && (act == ACT_NOTE_ON)) begin
					state_d = FR_EVAL;
				end
			end
			FR_EVAL: state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			FR_IDLE: begin
				eval_en = 1'b0;
				busy    = q_full;
			end
			FR_EVAL: begin
				eval_en = 1'b1;
				busy    = 1'b1;
			end
			default: begin
				eval_en = 1'b0;
				busy    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			trans_q <= transposition;
			draw_q  <= random_draw;
			time_q  <= sample_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_IDLE;
			pos_q      <= '0;
			step_vld_q <= '0;
			snd_vld_q  <= 1'b0;
			snd_note_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (act)
					ACT_WRITE: begin
						if (idx_in_len) begin
							step_vld_q[POS_W'(step_index)] <= 1'b1;
						end
					end
					ACT_ERASE: begin
						if (idx_in_len) begin
							step_vld_q[POS_W'(step_index)] <= 1'b0;
						end
					end
					ACT_SET_POS: begin
						pos_q <= (EFF_W'(step_index) < EFF_W'(MAX_STEPS)) ?
							POS_W'(step_index) : '0;
					end
					ACT_ADVANCE: begin
						pos_q <= (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
					end
					ACT_NOTE_OFF: snd_vld_q <= 1'b0;
					default: ;
				endcase
			end
			if (fire) begin
				snd_vld_q  <= 1'b1;
				snd_note_q <= note_clamped;
			end
		end
	end

	a_eval_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_EVAL |=> state_q == FR_IDLE) else $error("evaluation overran");
	a_fire_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> $past(ram_re)) else $error("note-on fired without table read");
	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && off_push)) else $error("two commands in one cycle");

endmodule

// File: design/ssv_back.sv
// ----------------------------------------------------------------------------
// ssv_back
// Event emitter: takes one command from the queue and walks the channel
// mask, sending one event per enabled channel and marking the final one.
// ----------------------------------------------------------------------------
module ssv_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ssv_pkg::MASK_W-1:0] channel_mask,
	input  logic                       q_empty,
	input  ssv_pkg::cmd_t              head_cmd,
	output logic                       pop,
	output logic                       strobe,
	output logic                       event_kind,
	output logic [4:0]                 midi_channel,
	output logic [6:0]                 midi_note,
	output logic [6:0]                 midi_velocity,
	output logic [15:0]                event_time,
	output logic                       last_event
);
	import ssv_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	cmd_t              cmd_q;
	logic [CH_W-1:0]   ch_q;
	logic [MASK_W-1:0] mask_eff;
	logic [MASK_W-1:0] above;
	logic              emit;
	logic              done;
	logic              strobe_q;
	logic              last_q;
	logic [4:0]        chan_q;
	cmd_t              out_q;

	assign mask_eff = channel_mask & CH_VALID;
	// enabled channels above the current one
	assign above    = (mask_eff >> ch_q) >> 1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			BK_IDLE: begin
				pop  = !q_empty;
				emit = 1'b0;
				done = 1'b0;
			end
			BK_RUN: begin
				pop  = 1'b0;
				emit = mask_eff[ch_q];
				done = (above == '0);
			end
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			out_q  <= cmd_q;
			chan_q <= 5'(ch_q) + 5'd1;
			last_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			ch_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (pop) begin
				ch_q <= '0;
			end else if (state_q == BK_RUN && !done) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	assign strobe        = strobe_q;
	assign event_kind    = out_q.kind;
	assign midi_channel  = chan_q;
	assign midi_note     = out_q.note;
	assign midi_velocity = out_q.vel;
	assign event_time    = out_q.time_stamp;
	assign last_event    = last_q;

	a_strobe_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == BK_RUN)) else $error("event outside run");
	a_done_leaves_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN && done) |=> state_q == BK_IDLE) else $error("run overran");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == BK_IDLE) else $error("pop while emitting");

endmodule

// File: design/step_sequencer_voice_core.sv
// ----------------------------------------------------------------------------
// step_sequencer_voice_core
// One voice of a step sequencer with a 64-step table, play position and
// per-channel note-on and note-off event generation.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Table writes, erases,
// position moves and note-offs are done in the front end as the word is taken;
// a note-on is then evaluated in the FR_EVAL state, as the step is read from
// the table RAM with a registered read. Each note command goes through a
// two-word queue to the emitter, which takes it in its idle state and then
// steps through the channels up to the highest enabled one. Events leave at
// most one per cycle on strobe, with gaps for disabled channels, and cannot
// be held off. busy rises while a note-on is looked up or the queue is full.
// Step table validity is held in flip-flops, so no clearing pass follows reset.
// Configuration: channel_mask at byte address 0, sequence_length at 4.
module step_sequencer_voice_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [5:0]  step_index,
	input  logic [7:0]  note_number,
	input  logic [6:0]  note_velocity,
	input  logic [8:0]  note_probability,
	input  logic [7:0]  transposition,
	input  logic [7:0]  random_draw,
	input  logic [15:0] sample_offset,
	output logic        strobe,
	output logic        event_kind,
	output logic [4:0]  midi_channel,
	output logic [6:0]  midi_note,
	output logic [6:0]  midi_velocity,
	output logic [15:0] event_time,
	output logic        last_event,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ssv_pkg::*;

	logic [MASK_W-1:0] channel_mask_q;
	logic [LEN_W-1:0]  seq_length_q;
	logic              cfg_wr;
	reg_index_t        reg_sel;
	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              head_cmd;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mask_q <= MASK_RESET;
			seq_length_q   <= LEN_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CHANNEL_MASK: channel_mask_q <= pwdata[MASK_W-1:0];
				REG_SEQ_LENGTH:   seq_length_q   <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CHANNEL_MASK: prdata = DATA_W'(channel_mask_q);
			REG_SEQ_LENGTH:   prdata = DATA_W'(seq_length_q);
			default:          prdata = '0;
		endcase
	end

	ssv_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.step_index       (step_index),
		.note_number      (note_number),
		.note_velocity    (note_velocity),
		.note_probability (note_probability),
		.transposition    (transposition),
		.random_draw      (random_draw),
		.sample_offset    (sample_offset),
		.seq_length       (seq_length_q),
		.q_full           (q_full),
		.push             (push),
		.push_cmd         (push_cmd)
	);

	ssv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	ssv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_mask  (channel_mask_q),
		.q_empty       (q_empty),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.strobe        (strobe),
		.event_kind    (event_kind),
		.midi_channel  (midi_channel),
		.midi_note     (midi_note),
		.midi_velocity (midi_velocity),
		.event_time    (event_time),
		.last_event    (last_event)
	);

endmodule

// File: sim/ssv_event_checker.sv
// ----------------------------------------------------------------------------
// ssv_event_checker
// Passive checker for the step sequencer voice. It follows the register port
// and every accepted word, keeps its own copy of the step table, play
// position and sounding note, and compares each emitted event in order.
// ----------------------------------------------------------------------------
module ssv_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  action,
	input  logic [5:0]  step_index,
	input  logic [7:0]  note_number,
	input  logic [6:0]  note_velocity,
	input  logic [8:0]  note_probability,
	input  logic [7:0]  transposition,
	input  logic [7:0]  random_draw,
	input  logic [15:0] sample_offset,
	input  logic        strobe,
	input  logic        event_kind,
	input  logic [4:0]  midi_channel,
	input  logic [6:0]  midi_note,
	input  logic [6:0]  midi_velocity,
	input  logic [15:0] event_time,
	input  logic        last_event,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	import ssv_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [4:0]  channel;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [15:0] stamp;
		logic        last;
	} midi_event_t;

	step_entry_t       steps [MAX_STEPS];
	logic [POS_W-1:0]  play_pos;
	logic [7:0]        sounding;
	logic [MASK_W-1:0] chan_mask;
	logic [LEN_W-1:0]  seq_len;
	midi_event_t       expected_events [$];
	int                errors;

	function automatic int active_length();
		if (seq_len == 0)
			return 1;
		if (int'(seq_len) > MAX_STEPS)
			return MAX_STEPS;
		return int'(seq_len);
	endfunction

	// one event per enabled channel, lowest channel first
	task automatic queue_events(input logic kind, input logic [6:0] note,
			input logic [6:0] vel, input logic [15:0] stamp);
		int total;
		int k;
		midi_event_t ev;
		total = $countones(chan_mask & CH_VALID);
		k = 0;
		for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
			if (chan_mask[ch]) begin
				k++;
				ev.kind    = kind;
				ev.channel = 5'(ch + 1);
				ev.note    = note;
				ev.vel     = vel;
				ev.stamp   = stamp;
				ev.last    = (k == total);
				expected_events.push_back(ev);
			end
		end
	endtask

	task automatic predict_word();
		int len;
		int pitch;
		step_entry_t s;
		len = active_length();
		case (action)
			ACT_WRITE: begin
				if (int'(step_index) < len)
					steps[step_index] = '{note: note_number, vel: note_velocity,
						prob: note_probability};
			end
			ACT_ERASE: begin
				if (int'(step_index) < len)
					steps[step_index].note = NOTE_EMPTY;
			end
			ACT_SET_POS: begin
				play_pos = (int'(step_index) < MAX_STEPS) ? POS_W'(step_index) : '0;
			end
			ACT_ADVANCE: begin
				if (int'(play_pos) + 1 >= len)
					play_pos = '0;
				else
					play_pos = play_pos + 1'b1;
			end
			ACT_NOTE_ON: begin
				if (int'(play_pos) < len) begin
					s = steps[play_pos];
					if (s.note != NOTE_EMPTY && random_draw <= s.prob) begin
						pitch = int'($signed(s.note)) + int'($signed(transposition));
						if (pitch < 0)
							pitch = 0;
						if (pitch > int'(NOTE_MAX))
							pitch = int'(NOTE_MAX);
						sounding = 8'(pitch);
						queue_events(EV_NOTE_ON, 7'(pitch), s.vel, sample_offset);
					end
				end
			end
			ACT_NOTE_OFF: begin
				if (sounding != NOTE_EMPTY)
					queue_events(EV_NOTE_OFF, sounding[6:0], '0, sample_offset);
				sounding = NOTE_EMPTY;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_event();
		midi_event_t want;
		if (expected_events.size() == 0) begin
			$error("event with none expected: kind %0d channel %0d note %0d",
				event_kind, midi_channel, midi_note);
			errors++;
		end else begin
			want = expected_events.pop_front();
			if (event_kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
				errors++;
			end
			if (midi_channel !== want.channel) begin
				$error("midi_channel: expected %0d, got %0d", want.channel, midi_channel);
				errors++;
			end
			if (midi_note !== want.note) begin
				$error("midi_note: expected %0d, got %0d", want.note, midi_note);
				errors++;
			end
			if (midi_velocity !== want.vel) begin
				$error("midi_velocity: expected %0d, got %0d", want.vel, midi_velocity);
				errors++;
			end
			if (event_time !== want.stamp) begin
				$error("event_time: expected %0d, got %0d", want.stamp, event_time);
				errors++;
			end
			if (last_event !== want.last) begin
				$error("last_event: expected %0d, got %0d", want.last, last_event);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STEPS; i++)
				steps[i] = '{note: NOTE_EMPTY, vel: '0, prob: '0};
			play_pos  = '0;
			sounding  = NOTE_EMPTY;
			chan_mask = MASK_RESET;
			seq_len   = LEN_RESET;
			expected_events.delete();
			errors = 0;
		end else begin
			// an event at this edge always belongs to an earlier word
			if (strobe)
				check_event();
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					{REG_CHANNEL_MASK, 2'b00}: chan_mask = pwdata[MASK_W-1:0];
					{REG_SEQ_LENGTH, 2'b00}:   seq_len   = pwdata[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (start && !busy)
				predict_word();
		end
		fail_count <= errors;
		pending    <= expected_events.size();
	end

endmodule

// File: sim/step_sequencer_voice_core_test.sv
// ----------------------------------------------------------------------------
// step_sequencer_voice_core_test
// Stimulus and verdict for the step sequencer voice: a directed opening on
// the reset settings, then random words over several register settings,
// sent in bursts with random gaps. Checking is done by ssv_event_checker.
// ----------------------------------------------------------------------------
module step_sequencer_voice_core_test;
	import ssv_pkg::*;

	localparam int ITEM_COUNT    = 260;
	localparam int PHASE_COUNT   = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 64;

	// codes the block does not act on
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        start            = 1'b0;
	logic        busy;
	logic [2:0]  action           = '0;
	logic [5:0]  step_index       = '0;
	logic [7:0]  note_number      = '0;
	logic [6:0]  note_velocity    = '0;
	logic [8:0]  note_probability = '0;
	logic [7:0]  transposition    = '0;
	logic [7:0]  random_draw      = '0;
	logic [15:0] sample_offset    = '0;
	logic        strobe;
	logic        event_kind;
	logic [4:0]  midi_channel;
	logic [6:0]  midi_note;
	logic [6:0]  midi_velocity;
	logic [15:0] event_time;
	logic        last_event;
	logic        psel             = 1'b0;
	logic        penable          = 1'b0;
	logic        pwrite           = 1'b0;
	logic [2:0]  paddr            = '0;
	logic [31:0] pwdata           = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;
	int cur_len     = 16;
	int words_sent  = 0;

	step_sequencer_voice_core i_dut (.*);

	ssv_event_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_word(input logic [2:0] act, input logic [5:0] idx,
			input logic [7:0] nn, input logic [6:0] vel, input logic [8:0] prob,
			input logic [7:0] trans, input logic [7:0] draw, input logic [15:0] offs);
		int r;
		int gap;
		start            <= 1'b1;
		action           <= act;
		step_index       <= idx;
		note_number      <= nn;
		note_velocity    <= vel;
		note_probability <= prob;
		transposition    <= trans;
		random_draw      <= draw;
		sample_offset    <= offs;
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(12, 1);
			r = $urandom_range(9);
			gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(4, 1) : $urandom_range(24, 5);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every expected event, then for the emitter to run dry
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input reg_index_t r, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] mask, input logic [6:0] len);
		settle();
		reg_write(REG_CHANNEL_MASK, {16'h0, mask});
		// let the bus go idle between the two register writes
		@(posedge clk);
		reg_write(REG_SEQ_LENGTH, {25'h0, len});
		cur_len = (len == 0) ? 1 : (int'(len) > MAX_STEPS) ? MAX_STEPS : int'(len);
	endtask

	task automatic random_word();
		int pick;
		logic [2:0] act;
		logic [5:0] idx;
		logic [7:0] nn;
		logic [8:0] prob;
		logic [7:0] trans;
		pick = $urandom_range(99);
		if (pick < 22)
			act = ACT_WRITE;
		else if (pick < 30)
			act = ACT_ERASE;
		else if (pick < 40)
			act = ACT_SET_POS;
		else if (pick < 62)
			act = ACT_ADVANCE;
		else if (pick < 82)
			act = ACT_NOTE_ON;
		else if (pick < 97)
			act = ACT_NOTE_OFF;
		else
			act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
		// mostly inside the active length so that the table fills up
		idx = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(cur_len - 1));
		if ($urandom_range(9) == 0)
			nn = NOTE_EMPTY;
		else
			nn = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(96, 36));
		prob = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(256, 128));
		trans = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(24)) - 8'd12;
		send_word(act, idx, nn, 7'($urandom), prob, trans, 8'($urandom), 16'($urandom));
		if (act != ACT_SPARE_A && act != ACT_SPARE_B)
			words_sent++;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one channel, sixteen steps
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_OFF, 6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0001);
		send_word(ACT_WRITE,    6'd0,  8'd60,  7'd127, 9'd256, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd255, 16'hFFFF);
		send_word(ACT_NOTE_OFF, 6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_WRITE,    6'd1,  8'd127, 7'd0,   9'd0,   8'd0,   8'd0,   16'h1234);
		send_word(ACT_ADVANCE,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		// draw just above a zero probability, then equal to it
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd127, 8'd1,   16'h0002);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd127, 8'd0,   16'h0003);
		send_word(ACT_WRITE,    6'd2,  8'h80,  7'd64,  9'd300, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_ADVANCE,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'h80,  8'd255, 16'h8000);
		// negative stored note that is not the empty marker
		send_word(ACT_WRITE,    6'd3,  8'hFB,  7'd100, 9'd511, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_SET_POS,  6'd3,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd10,  8'd200, 16'h00FF);
		send_word(ACT_ERASE,    6'd3,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_OFF, 6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'hABCD);
		// beyond the active length
		send_word(ACT_WRITE,    6'd20, 8'd70,  7'd90,  9'd256, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_SET_POS,  6'd20, 8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_NOTE_ON,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_ADVANCE,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_SET_POS,  6'd63, 8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_ADVANCE,  6'd0,  8'd0,   7'd0,   9'd0,   8'd0,   8'd0,   16'h0000);
		send_word(ACT_SPARE_A,  6'd0,  8'd60,  7'd1,   9'd256, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_SPARE_B,  6'd0,  8'd60,  7'd1,   9'd256, 8'd0,   8'd0,   16'h0000);
		send_word(ACT_WRITE,    6'd0,  NOTE_EMPTY, 7'd5, 9'd256, 8'd0, 8'd0,   16'h0000);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: set_config(16'hFFFF, 7'd64);
				1: set_config(16'h0000, 7'd0);
				2: set_config(16'h8000, 7'd127);
				3: set_config(16'h8001, 7'd1);
				4: set_config(16'h5AA5, 7'd2);
				5: set_config(16'($urandom), 7'($urandom));
				default: set_config(16'($urandom), 7'($urandom_range(64, 1)));
			endcase
			while (words_sent < ITEM_COUNT * (p + 1) / PHASE_COUNT)
				random_word();
		end

		settle();
		if (pending != 0)
			$error("%0d expected events never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
design/ssv_pkg.sv
design/ssv_ram.sv
design/ssv_queue.sv
design/ssv_front.sv
design/ssv_back.sv
design/step_sequencer_voice_core.sv
sim/ssv_event_checker.sv
sim/step_sequencer_voice_core_test.sv
